/* hw/rtl/psa_pkg.sv */
// ============================================================================
// psa_pkg: shared types and constants of the page slot allocator
// Field widths of the request, response and configuration channels, the
// operation and status codes, and the sequencer states.
// ============================================================================
package psa_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned PageIdW  = 7;
  localparam int unsigned SlotIdW  = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 10;
  localparam int unsigned SppW     = 4;
  localparam int unsigned FillW    = 4;

  localparam logic [SppW-1:0] SppReset = 4'd3;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_UPDATE = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NOPAGE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_INS_TOP,
    S_INS_PG,
    S_INS_MOD,
    S_RESP
  } state_e;

endpackage

/* hw/rtl/psa_if.sv */
// ============================================================================
// psa_if: valid/ready channels of the page slot allocator
// Request, response and configuration channels, each with a source and a
// sink modport.
// ============================================================================
interface psa_req_if;
  logic                              valid;
  logic                              ready;
  logic [psa_pkg::FuncW-1:0]         func;
  logic [psa_pkg::PageIdW-1:0]       page_id;
  logic [psa_pkg::SlotIdW-1:0]       slot_id;

  modport source (output valid, output func, output page_id, output slot_id, input ready);
  modport sink   (input valid, input func, input page_id, input slot_id, output ready);
endinterface

interface psa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [psa_pkg::StatusW-1:0]       status;
  logic [psa_pkg::PageIdW-1:0]       result_page;
  logic [psa_pkg::SlotIdW-1:0]       result_slot;
  logic [psa_pkg::CountW-1:0]        record_count;

  modport source (output valid, output status, output result_page, output result_slot,
                  output record_count, input ready);
  modport sink   (input valid, input status, input result_page, input result_slot,
                  input record_count, output ready);
endinterface

interface psa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psa_pkg::SppW-1:0]          slots_per_page;

  modport source (output valid, output slots_per_page, input ready);
  modport sink   (input valid, input slots_per_page, output ready);
endinterface

/* hw/rtl/page_slot_allocator.sv */
// ============================================================================
// page_slot_allocator: bitmap slot allocator with a stack of open pages
// Keeps an occupancy bitmap and fill count per page in one memory and the
// pages with free slots in a second memory used as a stack.
// ============================================================================
//
//  channel  dir  carries                                   accepted when
//  -------  ---  ----------------------------------------  ----------------
//  req_i    in   func, page_id, slot_id                    valid && ready
//  rsp_o    out  status, result_page, result_slot,         valid && ready
//                record_count
//  cfg_i    in   slots_per_page                            valid && ready
//
//  A lookup or a delete passes through S_CHK, an insert through S_INS_TOP,
//  S_INS_PG if it takes the stack top, and S_INS_MOD, an update through
//  S_CHK and, if its slot is occupied, the insert states; all then load the
//  response register from S_RESP. Memory reads are registered: an insert
//  reads the stack top and then the page it names. The sequencer returns to
//  idle as the response is loaded and accepts the next request there. Reset
//  clears the sequencer, the counters and the output valid flag. Neither
//  memory is cleared: a page entry is only used once its page is open, and
//  the insert that opens a page writes it. A stack entry is only read below
//  the stack depth. A stalled response holds in the output register while
//  the next request is accepted and processed up to its response.
//
module page_slot_allocator #(
  parameter int unsigned MAX_PAGES     = 64,
  parameter int unsigned SLOT_MAP_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  psa_req_if.sink         req_i,
  psa_rsp_if.source       rsp_o,
  psa_cfg_if.sink         cfg_i
);

  // Page numbers run 0..MAX_PAGES, memory indices 0..MAX_PAGES-1.
  localparam int unsigned PW      = $clog2(MAX_PAGES + 1);
  localparam int unsigned IW      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW      = (PW > psa_pkg::PageIdW) ? PW : psa_pkg::PageIdW;
  localparam int unsigned MAP_CAP = (SLOT_MAP_BITS < 8) ? SLOT_MAP_BITS : 8;
  localparam int unsigned PM_W    = SLOT_MAP_BITS + psa_pkg::FillW;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  psa_pkg::state_e                 state_q, state_d;
  logic [psa_pkg::SppW-1:0]        spp_cfg_q;
  psa_pkg::func_e                  func_q, func_d;
  logic [CW-1:0]                   page_q, page_d;
  logic [psa_pkg::SlotIdW-1:0]     slot_q, slot_d;
  logic                            fresh_q, fresh_d;
  logic [PW-1:0]                   pages_in_use_q, pages_in_use_d;
  logic [PW-1:0]                   stack_depth_q, stack_depth_d;
  logic [psa_pkg::CountW-1:0]      total_q, total_d;
  psa_pkg::status_e                res_status_q, res_status_d;
  logic [psa_pkg::PageIdW-1:0]     res_page_q, res_page_d;
  logic [psa_pkg::SlotIdW-1:0]     res_slot_q, res_slot_d;
  logic                            out_valid_q, out_valid_d;
  logic [psa_pkg::StatusW-1:0]     out_status_q, out_status_d;
  logic [psa_pkg::PageIdW-1:0]     out_page_q, out_page_d;
  logic [psa_pkg::SlotIdW-1:0]     out_slot_q, out_slot_d;
  logic [psa_pkg::CountW-1:0]      out_count_q, out_count_d;

  // --------------------------------------------------------------------------
  // Memories: page bitmap and fill count, and the open page stack
  // --------------------------------------------------------------------------
  logic [PM_W-1:0] page_mem [MAX_PAGES];
  logic [PW-1:0]   stack_mem [MAX_PAGES];

  logic            pm_re, pm_we;
  logic [IW-1:0]   pm_raddr, pm_waddr;
  logic [PM_W-1:0] pm_wdata, pm_rdata_q;
  logic            st_re, st_we;
  logic [IW-1:0]   st_raddr, st_waddr;
  logic [PW-1:0]   st_wdata, st_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      page_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_q <= page_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= stack_mem[st_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Shared datapath
  // --------------------------------------------------------------------------
  logic                        req_fire;
  logic                        out_free;
  logic [psa_pkg::SppW-1:0]    spp;
  logic [SLOT_MAP_BITS-1:0]    rd_bitmap, pg_bitmap, bm_shift;
  logic [psa_pkg::FillW-1:0]   rd_fill, pg_fill, fill_dec, fill_inc;
  logic                        page_ok, occupied;
  logic                        pages_full, stack_full, top_ok;
  logic [7:0]                  bm8;
  logic                        free_found;
  logic [psa_pkg::SlotIdW-1:0] free_slot;

  assign req_fire   = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign pages_full = (pages_in_use_q >= PW'(MAX_PAGES));
  assign stack_full = (stack_depth_q >= PW'(MAX_PAGES));

  // Effective slots per page, saturated into 1..MAP_CAP.
  always_comb begin
    if (spp_cfg_q == '0) begin
      spp = psa_pkg::SppW'(1);
    end else if (spp_cfg_q > psa_pkg::SppW'(MAP_CAP)) begin
      spp = psa_pkg::SppW'(MAP_CAP);
    end else begin
      spp = spp_cfg_q;
    end
  end

  assign rd_bitmap = pm_rdata_q[PM_W-1:psa_pkg::FillW];
  assign rd_fill   = pm_rdata_q[psa_pkg::FillW-1:0];

  // A page just opened has never been written and counts as empty.
  assign pg_bitmap = fresh_q ? '0 : rd_bitmap;
  assign pg_fill   = fresh_q ? '0 : rd_fill;

  assign page_ok  = (page_q != '0) && (page_q <= CW'(pages_in_use_q));
  assign bm_shift = rd_bitmap >> slot_q;
  assign occupied = page_ok && (int'(slot_q) < SLOT_MAP_BITS) && bm_shift[0];
  assign fill_dec = (rd_fill != '0) ? rd_fill - 1'b1 : rd_fill;
  assign fill_inc = pg_fill + 1'b1;
  assign top_ok   = (st_rdata_q != '0) && (st_rdata_q <= pages_in_use_q);

  // Lowest free slot among the usable ones.
  assign bm8 = 8'(pg_bitmap);
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 7; i >= 0; i--) begin
      if ((i < int'(spp)) && !bm8[i]) begin
        free_found = 1'b1;
        free_slot  = psa_pkg::SlotIdW'(i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psa_pkg::S_IDLE: begin
        if (req_fire) begin
          state_d = (psa_pkg::func_e'(req_i.func) == psa_pkg::FUNC_INSERT) ?
                    psa_pkg::S_INS_TOP : psa_pkg::S_CHK;
        end
      end
      psa_pkg::S_CHK: begin
        if (func_q == psa_pkg::FUNC_UPDATE && occupied) begin
          state_d = psa_pkg::S_INS_TOP;
        end else begin
          state_d = psa_pkg::S_RESP;
        end
      end
      psa_pkg::S_INS_TOP: begin
        if (stack_depth_q != '0) begin
          state_d = psa_pkg::S_INS_PG;
        end else if (pages_full) begin
          state_d = psa_pkg::S_RESP;
        end else begin
          state_d = psa_pkg::S_INS_MOD;
        end
      end
      psa_pkg::S_INS_PG: begin
        state_d = top_ok ? psa_pkg::S_INS_MOD : psa_pkg::S_RESP;
      end
      psa_pkg::S_INS_MOD: begin
        state_d = psa_pkg::S_RESP;
      end
      psa_pkg::S_RESP: begin
        if (out_free) begin
          state_d = psa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psa_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: memory accesses and register updates
  // --------------------------------------------------------------------------
  always_comb begin
    func_d         = func_q;
    page_d         = page_q;
    slot_d         = slot_q;
    fresh_d        = fresh_q;
    pages_in_use_d = pages_in_use_q;
    stack_depth_d  = stack_depth_q;
    total_d        = total_q;
    res_status_d   = res_status_q;
    res_page_d     = res_page_q;
    res_slot_d     = res_slot_q;
    out_valid_d    = out_valid_q && !rsp_o.ready;
    out_status_d   = out_status_q;
    out_page_d     = out_page_q;
    out_slot_d     = out_slot_q;
    out_count_d    = out_count_q;
    pm_re          = 1'b0;
    pm_raddr       = IW'(page_q - 1'b1);
    pm_we          = 1'b0;
    pm_waddr       = IW'(page_q - 1'b1);
    pm_wdata       = '0;
    st_re          = 1'b0;
    st_raddr       = IW'(stack_depth_q - 1'b1);
    st_we          = 1'b0;
    st_waddr       = IW'(stack_depth_q);
    st_wdata       = '0;

    unique case (state_q)
      psa_pkg::S_IDLE: begin
        if (req_fire) begin
          func_d     = psa_pkg::func_e'(req_i.func);
          page_d     = CW'(req_i.page_id);
          slot_d     = req_i.slot_id;
          fresh_d    = 1'b0;
          res_status_d = psa_pkg::STATUS_OK;
          res_page_d = '0;
          res_slot_d = '0;
          pm_re      = 1'b1;
          pm_raddr   = IW'(CW'(req_i.page_id) - 1'b1);
        end
      end

      psa_pkg::S_CHK: begin
        if (func_q == psa_pkg::FUNC_LOOKUP) begin
          res_status_d = occupied ? psa_pkg::STATUS_OK : psa_pkg::STATUS_INVALID;
        end else if (!occupied) begin
          res_status_d = psa_pkg::STATUS_INVALID;
        end else begin
          // Delete, and the first step of an update: clear the bit, and reopen the
          // page when it drops from full to one short of full and the stack has room.
          pm_we    = 1'b1;
          pm_wdata = {rd_bitmap & ~(SLOT_MAP_BITS'(1) << slot_q), fill_dec};
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
          if (({1'b0, fill_dec} + 1'b1) == {1'b0, spp} && !stack_full) begin
            st_we         = 1'b1;
            st_wdata      = PW'(page_q);
            stack_depth_d = stack_depth_q + 1'b1;
          end
          res_status_d = psa_pkg::STATUS_OK;
        end
      end

      psa_pkg::S_INS_TOP: begin
        if (stack_depth_q != '0) begin
          st_re = 1'b1;
        end else if (pages_full) begin
          res_status_d = psa_pkg::STATUS_NOPAGE;
        end else begin
          // Open the next page and put it on the empty stack.
          pages_in_use_d = pages_in_use_q + 1'b1;
          st_we          = 1'b1;
          st_wdata       = pages_in_use_q + 1'b1;
          stack_depth_d  = stack_depth_q + 1'b1;
          page_d         = CW'(pages_in_use_q + 1'b1);
          fresh_d        = 1'b1;
        end
      end

      psa_pkg::S_INS_PG: begin
        if (!top_ok) begin
          stack_depth_d = stack_depth_q - 1'b1;
          res_status_d  = psa_pkg::STATUS_NOPAGE;
        end else begin
          page_d   = CW'(st_rdata_q);
          fresh_d  = 1'b0;
          pm_re    = 1'b1;
          pm_raddr = IW'(st_rdata_q - 1'b1);
        end
      end

      psa_pkg::S_INS_MOD: begin
        if (!free_found) begin
          // Stale top after the slot count was lowered: drop it.
          stack_depth_d = stack_depth_q - 1'b1;
          res_status_d  = psa_pkg::STATUS_NOPAGE;
        end else begin
          pm_we    = 1'b1;
          pm_wdata = {pg_bitmap | (SLOT_MAP_BITS'(1) << free_slot), fill_inc};
          total_d  = total_q + 1'b1;
          if (fill_inc >= spp) begin
            stack_depth_d = stack_depth_q - 1'b1;
          end
          res_status_d = psa_pkg::STATUS_OK;
          res_page_d   = psa_pkg::PageIdW'(page_q);
          res_slot_d   = free_slot;
        end
      end

      psa_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_page_d   = res_page_q;
          out_slot_d   = res_slot_q;
          out_count_d  = total_q;
        end
      end

      default: begin
        out_valid_d = out_valid_q && !rsp_o.ready;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= psa_pkg::S_IDLE;
      spp_cfg_q      <= psa_pkg::SppReset;
      pages_in_use_q <= '0;
      stack_depth_q  <= '0;
      total_q        <= '0;
      fresh_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      pages_in_use_q <= pages_in_use_d;
      stack_depth_q  <= stack_depth_d;
      total_q        <= total_d;
      fresh_q        <= fresh_d;
      out_valid_q    <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        spp_cfg_q <= cfg_i.slots_per_page;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    page_q       <= page_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign req_i.ready        = (state_q == psa_pkg::S_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.result_page  = out_page_q;
  assign rsp_o.result_slot  = out_slot_q;
  assign rsp_o.record_count = out_count_q;

`ifndef SYNTH
  // The stack never holds more entries than it has room for.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_depth_q <= PW'(MAX_PAGES))
    else $error("open page stack deeper than its capacity");

  // Pages are never closed once opened.
  a_pages_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> pages_in_use_q >= $past(pages_in_use_q))
    else $error("pages in use decreased");

  // A new response only appears after the response state.
  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == psa_pkg::S_RESP))
    else $error("response raised outside the response state");

  // An accepted request starts the sequencer.
  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=>
      (state_q == psa_pkg::S_CHK || state_q == psa_pkg::S_INS_TOP))
    else $error("accepted request did not start an operation");
`endif

endmodule
